// ===== rtl/hessian_gaussian_disk_average_core_macros.svh =====
// assertion macros shared by the hessian disk average rtl
`ifndef HESSIAN_GAUSSIAN_DISK_AVERAGE_CORE_MACROS_SVH
`define HESSIAN_GAUSSIAN_DISK_AVERAGE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HGDA_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("hgda same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define HGDA_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("hgda next-cycle check failed");

`endif

// ===== rtl/hgda_pkg.sv =====
// package: constants, codes, types and helpers of the hessian disk average block
`timescale 1ns / 1ps
`default_nettype none
package hgda_pkg;

  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int HALF_WINDOW    = 3;
  localparam int RADIUS_INT_MAX = 15;

  localparam int NLANE   = 3;
  localparam int KSIDE   = 2 * HALF_WINDOW + 1;
  localparam int KTAPS   = KSIDE * KSIDE;
  localparam int KOFF_W  = $clog2(KSIDE);
  localparam int KIDX_W  = $clog2(KTAPS);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int CRD_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

  localparam int DIM_W   = 9;
  localparam int IN_COL_W = 8;
  localparam int IN_ROW_W = 8;
  localparam int PIX_W   = 16;
  localparam int COEF_W  = 24;
  localparam int TAP_W   = 6;
  localparam int SEL_W   = 2;
  localparam int RAD_W   = 8;
  localparam int R2_W    = 2 * RAD_W;
  localparam int PROD_W  = COEF_W + PIX_W + 1;
  localparam int PLANE_W = 48;

  localparam int RMAX_W  = $clog2(RADIUS_INT_MAX + 2);
  localparam int OFS_W   = RMAX_W + 1;
  localparam int D2_W    = 2 * RMAX_W + 1;
  localparam int QDIAM   = 2 * (RADIUS_INT_MAX + 1) + 1;
  localparam int QSUM_W  = PLANE_W + $clog2(QDIAM * QDIAM);
  localparam int NUM_W   = QSUM_W + 4;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  typedef enum logic [1:0] {
    OP_WRITE_PIXEL  = 2'd0,
    OP_WRITE_KERNEL = 2'd1,
    OP_COMPUTE      = 2'd2,
    OP_QUERY        = 2'd3
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    KSEL_XX = 2'd0,
    KSEL_YY = 2'd1,
    KSEL_XY = 2'd2
  } ksel_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP_RUN,
    S_COMP_DRAIN,
    S_QRY_RUN,
    S_QRY_DRAIN,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic wr_pix;
    logic wr_ker;
    logic load_item;
    logic comp_issue;
    logic qry_issue;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic comp_last;
    logic qry_last;
    logic pipe_empty;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [CRD_W-1:0] v,
                                                 input logic [COL_W-1:0] hi);
    logic [COL_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(CRD_W-COL_W){1'b0}}, hi})) begin
      res = hi;
    end else begin
      res = v[COL_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [CRD_W-1:0] v,
                                                 input logic [ROW_W-1:0] hi);
    logic [ROW_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(CRD_W-ROW_W){1'b0}}, hi})) begin
      res = hi;
    end else begin
      res = v[ROW_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hessian_gaussian_disk_average_core.sv =====
// top level: hessian planes by 7x7 kernels and disk-averaged query results
// writes of a pixel or a kernel coefficient leave the controller idle, the block is ready again next cycle
// compute: walks every tap of every pixel through the single image read port, then drains
// query: walks offsets -rmax..rmax on both axes, rmax = min(radius/16, 15)+1, then drains,
//   divides and loads the result register, one item at a time
// rst_n is synchronous: control returns to idle, width and height to 256, memories keep contents
`timescale 1ns / 1ps
`default_nettype none
module hessian_gaussian_disk_average_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_operation,
  input  wire logic [hgda_pkg::IN_COL_W-1:0]       in_col,
  input  wire logic [hgda_pkg::IN_ROW_W-1:0]       in_row,
  input  wire logic [hgda_pkg::PIX_W-1:0]          in_pixel_value,
  input  wire logic [hgda_pkg::SEL_W-1:0]          in_kernel_select,
  input  wire logic [hgda_pkg::TAP_W-1:0]          in_kernel_tap,
  input  wire logic signed [hgda_pkg::COEF_W-1:0]  in_coefficient,
  input  wire logic [hgda_pkg::RAD_W-1:0]          in_radius,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [hgda_pkg::PLANE_W-1:0]      out_hxx,
  output logic signed [hgda_pkg::PLANE_W-1:0]      out_hyy,
  output logic signed [hgda_pkg::PLANE_W-1:0]      out_hxy,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [hgda_pkg::APB_AW-1:0]         paddr,
  input  wire logic [hgda_pkg::APB_DW-1:0]         pwdata,
  output logic      [hgda_pkg::APB_DW-1:0]         prdata,
  output logic                                     pready
);
  import hgda_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  // frame size registers, saturated to 1..max before use
  hgda_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wm1     (wm1),
    .hm1     (hm1)
  );

  // state machine: accepts a request only when idle, then runs its walk
  hgda_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // memories, convolution pipeline, disk accumulator, divider and result register
  hgda_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .wm1              (wm1),
    .hm1              (hm1),
    .in_col           (in_col),
    .in_row           (in_row),
    .in_pixel_value   (in_pixel_value),
    .in_kernel_select (in_kernel_select),
    .in_kernel_tap    (in_kernel_tap),
    .in_coefficient   (in_coefficient),
    .in_radius        (in_radius),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hxx          (out_hxx),
    .out_hyy          (out_hyy),
    .out_hxy          (out_hxy)
  );
endmodule
`default_nettype wire

// ===== rtl/hgda_cfg.sv =====
// configuration registers: frame width and height behind an apb-style port
`timescale 1ns / 1ps
`default_nettype none
`include "hessian_gaussian_disk_average_core_macros.svh"
module hgda_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hgda_pkg::APB_AW-1:0] paddr,
  input  wire logic [hgda_pkg::APB_DW-1:0] pwdata,
  output logic      [hgda_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic      [hgda_pkg::COL_W-1:0]  wm1,
  output logic      [hgda_pkg::ROW_W-1:0]  hm1
);
  import hgda_pkg::*;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic             wr_en;
  reg_idx_t         idx;
  logic [DIM_W-1:0] eff_w, eff_h;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_nxt  = pwdata[DIM_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  // zero and oversize values saturate into 1..max
  always_comb begin
    if (width_r == '0) begin
      eff_w = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign wm1 = COL_W'(eff_w - DIM_W'(1));
  assign hm1 = ROW_W'(eff_h - DIM_W'(1));

  `HGDA_ASSERT_NXT(a_width_write, wr_en && (idx == REG_WIDTH), width_r == $past(pwdata[DIM_W-1:0]))
endmodule
`default_nettype wire

// ===== rtl/hgda_ctrl.sv =====
// controller: sequences writes, the plane computation, the disk walk and the divide
`timescale 1ns / 1ps
`default_nettype none
`include "hessian_gaussian_disk_average_core_macros.svh"
module hgda_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_operation,
  output logic                in_stall,
  output hgda_pkg::cmd_t      cmd,
  input  wire hgda_pkg::sts_t sts
);
  import hgda_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  op_t    op;

  assign op       = op_t'(in_operation);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (op == OP_COMPUTE)) begin
          state_nxt = S_COMP_RUN;
        end else if (accept && (op == OP_QUERY)) begin
          state_nxt = S_QRY_RUN;
        end
      end
      S_COMP_RUN:   if (sts.comp_last) state_nxt = S_COMP_DRAIN;
      S_COMP_DRAIN: if (sts.pipe_empty) state_nxt = S_IDLE;
      S_QRY_RUN:    if (sts.qry_last) state_nxt = S_QRY_DRAIN;
      S_QRY_DRAIN:  if (sts.pipe_empty) state_nxt = S_DIV;
      S_DIV:        if (sts.div_done) state_nxt = S_OUT;
      S_OUT:        if (sts.out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.wr_pix    = accept && (op == OP_WRITE_PIXEL);
        cmd.wr_ker    = accept && (op == OP_WRITE_KERNEL);
        cmd.load_item = accept;
      end
      S_COMP_RUN:   cmd.comp_issue = 1'b1;
      S_COMP_DRAIN: ;
      S_QRY_RUN:    cmd.qry_issue = 1'b1;
      S_QRY_DRAIN:  cmd.div_start = sts.pipe_empty;
      S_DIV:        cmd.div_step = !sts.div_done;
      S_OUT:        cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `HGDA_ASSERT_NXT(a_out_to_idle, (state_r == S_OUT) && sts.out_free, state_r == S_IDLE)
  `HGDA_ASSERT_NXT(a_comp_to_drain, (state_r == S_COMP_RUN) && sts.comp_last, state_r == S_COMP_DRAIN)
endmodule
`default_nettype wire

// ===== rtl/hgda_dp.sv =====
// datapath: image, kernel and plane memories, convolution and disk-sum pipelines, divider
`timescale 1ns / 1ps
`default_nettype none
`include "hessian_gaussian_disk_average_core_macros.svh"
module hgda_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hgda_pkg::cmd_t                      cmd,
  output hgda_pkg::sts_t                           sts,
  input  wire logic [hgda_pkg::COL_W-1:0]          wm1,
  input  wire logic [hgda_pkg::ROW_W-1:0]          hm1,
  input  wire logic [hgda_pkg::IN_COL_W-1:0]       in_col,
  input  wire logic [hgda_pkg::IN_ROW_W-1:0]       in_row,
  input  wire logic [hgda_pkg::PIX_W-1:0]          in_pixel_value,
  input  wire logic [hgda_pkg::SEL_W-1:0]          in_kernel_select,
  input  wire logic [hgda_pkg::TAP_W-1:0]          in_kernel_tap,
  input  wire logic signed [hgda_pkg::COEF_W-1:0]  in_coefficient,
  input  wire logic [hgda_pkg::RAD_W-1:0]          in_radius,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [hgda_pkg::PLANE_W-1:0]      out_hxx,
  output logic signed [hgda_pkg::PLANE_W-1:0]      out_hyy,
  output logic signed [hgda_pkg::PLANE_W-1:0]      out_hxy
);
  import hgda_pkg::*;

  // storage
  logic [PIX_W-1:0]          image_mem [NPIX];
  logic signed [COEF_W-1:0]  kern_mem  [NLANE][KTAPS];
  logic signed [PLANE_W-1:0] plane_mem [NLANE][NPIX];

  // item clamping
  logic [COL_W-1:0]  col_c;
  logic [ROW_W-1:0]  row_c;
  logic [RAD_W-1:0]  rad_eff;
  logic [RMAX_W-1:0] rint_c, rmax_in;

  assign col_c = clamp_col($signed(CRD_W'(in_col)), wm1);
  assign row_c = clamp_row($signed(CRD_W'(in_row)), hm1);
  assign rad_eff = (in_radius == '0) ? RAD_W'(1) : in_radius;
  assign rint_c  = ({1'b0, rad_eff[RAD_W-1:4]} > RMAX_W'(RADIUS_INT_MAX)) ?
                   RMAX_W'(RADIUS_INT_MAX) : RMAX_W'(rad_eff[RAD_W-1:4]);
  assign rmax_in = rint_c + RMAX_W'(1);

  // pixel writes
  always_ff @(posedge clk) begin
    if (cmd.wr_pix) begin
      image_mem[{row_c, col_c}] <= in_pixel_value;
    end
  end

  // ---------------- plane computation walk ----------------
  logic [COL_W-1:0]  cx_r, cx_nxt;
  logic [ROW_W-1:0]  cy_r, cy_nxt;
  logic [KOFF_W-1:0] kx_r, kx_nxt, ky_r, ky_nxt;
  logic [KIDX_W-1:0] kt_r, kt_nxt;
  logic              tap_first, tap_last;
  logic [COL_W-1:0]  img_x;
  logic [ROW_W-1:0]  img_y;

  assign tap_first = (kt_r == '0);
  assign tap_last  = (kx_r == KOFF_W'(KSIDE - 1)) && (ky_r == KOFF_W'(KSIDE - 1));

  assign img_x = clamp_col($signed(CRD_W'(cx_r)) + CRD_W'(HALF_WINDOW)
                           - $signed(CRD_W'(kx_r)), wm1);
  assign img_y = clamp_row($signed(CRD_W'(cy_r)) + CRD_W'(HALF_WINDOW)
                           - $signed(CRD_W'(ky_r)), hm1);

  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    kx_nxt = kx_r;
    ky_nxt = ky_r;
    kt_nxt = kt_r;
    if (cmd.load_item) begin
      cx_nxt = '0;
      cy_nxt = '0;
      kx_nxt = '0;
      ky_nxt = '0;
      kt_nxt = '0;
    end else if (cmd.comp_issue) begin
      kt_nxt = kt_r + KIDX_W'(1);
      kx_nxt = kx_r + KOFF_W'(1);
      if (kx_r == KOFF_W'(KSIDE - 1)) begin
        kx_nxt = '0;
        ky_nxt = ky_r + KOFF_W'(1);
        if (ky_r == KOFF_W'(KSIDE - 1)) begin
          ky_nxt = '0;
          kt_nxt = '0;
          cx_nxt = cx_r + COL_W'(1);
          if (cx_r == wm1) begin
            cx_nxt = '0;
            cy_nxt = cy_r + ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    kx_r <= kx_nxt;
    ky_r <= ky_nxt;
    kt_r <= kt_nxt;
  end

  // stage 1: memory reads
  logic                     cv1_r, cv2_r;
  logic [ADDR_W-1:0]        c1_addr_r, c2_addr_r;
  logic                     c1_first_r, c1_last_r, c2_first_r, c2_last_r;
  logic [PIX_W-1:0]         pix_rd_r;
  logic signed [COEF_W-1:0] kern_rd_r [NLANE];
  logic signed [PROD_W-1:0] prod_r    [NLANE];
  logic signed [PLANE_W-1:0] acc_r    [NLANE];
  logic signed [PLANE_W-1:0] acc_nxt  [NLANE];

  always_ff @(posedge clk) begin
    if (cmd.comp_issue) begin
      pix_rd_r <= image_mem[{img_y, img_x}];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      if (cmd.wr_ker && (in_kernel_select == SEL_W'(k)) && (in_kernel_tap < TAP_W'(KTAPS))) begin
        kern_mem[k][in_kernel_tap[KIDX_W-1:0]] <= in_coefficient;
      end
      if (cmd.comp_issue) begin
        kern_rd_r[k] <= kern_mem[k][kt_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    c1_addr_r  <= {cy_r, cx_r};
    c1_first_r <= tap_first;
    c1_last_r  <= tap_last;
    c2_addr_r  <= c1_addr_r;
    c2_first_r <= c1_first_r;
    c2_last_r  <= c1_last_r;
    for (int k = 0; k < NLANE; k++) begin
      prod_r[k] <= kern_rd_r[k] * $signed({1'b0, pix_rd_r});
    end
  end

  // stage 3: accumulate, store plane value after the last tap
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      acc_nxt[k] = c2_first_r ? PLANE_W'(prod_r[k]) : acc_r[k] + PLANE_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      if (cv2_r) begin
        acc_r[k] <= acc_nxt[k];
      end
    end
  end

  // ---------------- disk walk ----------------
  logic [COL_W-1:0]        qcol_r;
  logic [ROW_W-1:0]        qrow_r;
  logic [RAD_W-1:0]        r_r;
  logic [R2_W-1:0]         r2_r;
  logic [RMAX_W-1:0]       rmax_r;
  logic signed [OFS_W-1:0] qdx_r, qdx_nxt, qdy_r, qdy_nxt;
  logic [RMAX_W-1:0]       adx, ady;
  logic [D2_W-1:0]         d2;
  logic                    in_disk, qry_last;
  logic [COL_W-1:0]        pl_x;
  logic [ROW_W-1:0]        pl_y;
  logic                    qv1_r;
  logic signed [PLANE_W-1:0] plane_rd_r [NLANE];
  logic signed [QSUM_W-1:0]  qsum_r     [NLANE];

  assign adx = RMAX_W'(qdx_r[OFS_W-1] ? -qdx_r : qdx_r);
  assign ady = RMAX_W'(qdy_r[OFS_W-1] ? -qdy_r : qdy_r);
  assign d2  = D2_W'(adx) * D2_W'(adx) + D2_W'(ady) * D2_W'(ady);
  assign in_disk  = ({d2, 8'h00} <= (D2_W + 8)'(r2_r));
  assign qry_last = (qdx_r == $signed(OFS_W'(rmax_r))) && (qdy_r == $signed(OFS_W'(rmax_r)));
  assign pl_x = clamp_col($signed(CRD_W'(qcol_r)) - CRD_W'(qdx_r), wm1);
  assign pl_y = clamp_row($signed(CRD_W'(qrow_r)) - CRD_W'(qdy_r), hm1);

  always_comb begin
    qdx_nxt = qdx_r;
    qdy_nxt = qdy_r;
    if (cmd.load_item) begin
      qdx_nxt = -$signed(OFS_W'(rmax_in));
      qdy_nxt = -$signed(OFS_W'(rmax_in));
    end else if (cmd.qry_issue) begin
      if (qdx_r == $signed(OFS_W'(rmax_r))) begin
        qdx_nxt = -$signed(OFS_W'(rmax_r));
        qdy_nxt = qdy_r + OFS_W'(1);
      end else begin
        qdx_nxt = qdx_r + OFS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    qdx_r <= qdx_nxt;
    qdy_r <= qdy_nxt;
    if (cmd.load_item) begin
      qcol_r <= col_c;
      qrow_r <= row_c;
      r_r    <= rad_eff;
      r2_r   <= rad_eff * rad_eff;
      rmax_r <= rmax_in;
    end
  end

  // plane memories: written by the convolution, read by the disk walk
  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      if (cv2_r && c2_last_r) begin
        plane_mem[k][c2_addr_r] <= acc_nxt[k];
      end
      if (cmd.qry_issue && in_disk) begin
        plane_rd_r[k] <= plane_mem[k][{pl_y, pl_x}];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      if (cmd.load_item) begin
        qsum_r[k] <= '0;
      end else if (qv1_r) begin
        qsum_r[k] <= qsum_r[k] + QSUM_W'(plane_rd_r[k]);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv1_r <= 1'b0;
      cv2_r <= 1'b0;
      qv1_r <= 1'b0;
    end else begin
      cv1_r <= cmd.comp_issue;
      cv2_r <= cv1_r;
      qv1_r <= cmd.qry_issue && in_disk;
    end
  end

  // ---------------- divide by radius, one quotient bit per cycle ----------------
  logic [NUM_W-1:0]   num_r [NLANE];
  logic [RAD_W-1:0]   rem_r [NLANE];
  logic               neg_r [NLANE];
  logic [DCNT_W-1:0]  dcnt_r;
  logic [RAD_W:0]     trial [NLANE];
  logic               ge    [NLANE];
  logic [QSUM_W-1:0]  mag   [NLANE];

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      mag[k]   = qsum_r[k][QSUM_W-1] ? QSUM_W'(-qsum_r[k]) : QSUM_W'(qsum_r[k]);
      trial[k] = {rem_r[k], num_r[k][NUM_W-1]};
      ge[k]    = (trial[k] >= {1'b0, r_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dcnt_r <= '0;
      for (int k = 0; k < NLANE; k++) begin
        num_r[k] <= {mag[k], 4'h0};
        rem_r[k] <= '0;
        neg_r[k] <= qsum_r[k][QSUM_W-1];
      end
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + DCNT_W'(1);
      for (int k = 0; k < NLANE; k++) begin
        rem_r[k] <= ge[k] ? RAD_W'(trial[k] - {1'b0, r_r}) : trial[k][RAD_W-1:0];
        num_r[k] <= {num_r[k][NUM_W-2:0], ge[k]};
      end
    end
  end

  // ---------------- result register with 48-bit saturation ----------------
  logic                      out_valid_r;
  logic signed [PLANE_W-1:0] res     [NLANE];
  logic signed [PLANE_W-1:0] out_h_r [NLANE];

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      if (!neg_r[k]) begin
        res[k] = (num_r[k] > NUM_W'({1'b0, {(PLANE_W-1){1'b1}}})) ?
                 {1'b0, {(PLANE_W-1){1'b1}}} : num_r[k][PLANE_W-1:0];
      end else begin
        res[k] = (num_r[k] > NUM_W'({1'b1, {(PLANE_W-1){1'b0}}})) ?
                 {1'b1, {(PLANE_W-1){1'b0}}} : -num_r[k][PLANE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < NLANE; k++) begin
        out_h_r[k] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hxx   = out_h_r[KSEL_XX];
  assign out_hyy   = out_h_r[KSEL_YY];
  assign out_hxy   = out_h_r[KSEL_XY];

  assign sts.comp_last  = tap_last && (cx_r == wm1) && (cy_r == hm1);
  assign sts.qry_last   = qry_last;
  assign sts.pipe_empty = !cv1_r && !cv2_r && !qv1_r;
  assign sts.div_done   = (dcnt_r == DCNT_W'(NUM_W));
  assign sts.out_free   = !out_valid_r || !out_stall;

  `HGDA_ASSERT_IMP(a_no_pipe_overlap, qv1_r, !cv1_r && !cv2_r)
  `HGDA_ASSERT_NXT(a_out_loaded, cmd.out_load, out_valid_r)
endmodule
`default_nettype wire

// ===== sim/hessian_gaussian_disk_average_core_tb.sv =====
// testbench: hessian disk average core against a predictor of planes and disk sums
`timescale 1ns / 1ps
module hessian_gaussian_disk_average_core_tb;
  import hgda_pkg::*;

  // 48-bit signed bounds of planes and results
  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -64'sd140737488355328;
  // quotient bound past which the result saturates without scaling by sixteen
  localparam longint QUOT_LIM = 64'sd288230376151711743;
  localparam int IMG_N = MAX_WIDTH * MAX_HEIGHT;

  typedef struct {
    op_t         op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] pix;
    logic [1:0]  sel;
    logic [5:0]  tap;
    logic [23:0] coef;
    logic [7:0]  rad;
  } hreq_t;

  typedef struct {
    logic signed [PLANE_W-1:0] xx;
    logic signed [PLANE_W-1:0] yy;
    logic signed [PLANE_W-1:0] xy;
  } hres_t;

  // one row of the directed table, with a hand-typed result where one is known
  typedef struct {
    hreq_t req;
    bit    typed;
    hres_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [7:0] in_col = '0;
  logic [7:0] in_row = '0;
  logic [15:0] in_pixel_value = '0;
  logic [1:0] in_kernel_select = '0;
  logic [5:0] in_kernel_tap = '0;
  logic signed [23:0] in_coefficient = '0;
  logic [7:0] in_radius = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [PLANE_W-1:0] out_hxx, out_hyy, out_hxy;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  hessian_gaussian_disk_average_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_col(in_col), .in_row(in_row), .in_pixel_value(in_pixel_value),
    .in_kernel_select(in_kernel_select), .in_kernel_tap(in_kernel_tap),
    .in_coefficient(in_coefficient), .in_radius(in_radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hxx(out_hxx), .out_hyy(out_hyy), .out_hxy(out_hxy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // predictor state: frame, kernel tables, hessian planes, frame size registers
  logic [15:0] frame_px [IMG_N];
  bit          frame_ok [IMG_N];
  longint      kern_tab [3][KTAPS];
  longint      hess_plane [3][IMG_N];
  logic [8:0]  reg_w = 9'd256;
  logic [8:0]  reg_h = 9'd256;

  hres_t  pending_res [$];
  int     n_fail = 0;
  int     n_req = 0;
  int     n_query = 0;
  int     n_checked = 0;
  int     n_compute = 0;
  bit     calm = 0;
  bit     hold_req = 0;

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : int'(v);
  endfunction

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint sat48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // every plane value from the clamped 7x7 neighborhood
  function automatic void plane_build();
    int w, h, xk, yk, t;
    longint acc [3];
    longint p;
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        acc = '{0, 0, 0};
        for (int dy = -HALF_WINDOW; dy <= HALF_WINDOW; dy++) begin
          for (int dx = -HALF_WINDOW; dx <= HALF_WINDOW; dx++) begin
            xk = clamp_to(x - dx, w - 1);
            yk = clamp_to(y - dy, h - 1);
            p = longint'(frame_px[yk * MAX_WIDTH + xk]);
            t = (dx + HALF_WINDOW) + (dy + HALF_WINDOW) * KSIDE;
            for (int k = 0; k < 3; k++) acc[k] += kern_tab[k][t] * p;
          end
        end
        for (int k = 0; k < 3; k++) hess_plane[k][y * MAX_WIDTH + x] = sat48(acc[k]);
      end
    end
  endfunction

  // disk sum times sixteen over radius, truncated toward zero
  function automatic longint scale_by_radius(longint s, longint r);
    longint q, m;
    q = s / r;
    m = s % r;
    if (q > QUOT_LIM) return SAT_HI;
    if (q < -QUOT_LIM) return SAT_LO;
    return sat48(q * 16 + (m * 16) / r);
  endfunction

  function automatic hres_t disk_average(logic [7:0] c8, logic [7:0] r8, logic [7:0] rad);
    hres_t res;
    int w, h, col, row, rint, rmax, xk, yk;
    longint r, r2, d2;
    longint s [3];
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    col = clamp_to(int'(c8), w - 1);
    row = clamp_to(int'(r8), h - 1);
    r = (rad == 0) ? 1 : longint'(rad);
    rint = int'(r >> 4);
    if (rint > RADIUS_INT_MAX) rint = RADIUS_INT_MAX;
    rmax = rint + 1;
    r2 = r * r;
    s = '{0, 0, 0};
    for (int dy = -rmax; dy <= rmax; dy++) begin
      for (int dx = -rmax; dx <= rmax; dx++) begin
        d2 = longint'(dx * dx + dy * dy) * 256;
        if (d2 <= r2) begin
          xk = clamp_to(col - dx, w - 1);
          yk = clamp_to(row - dy, h - 1);
          for (int k = 0; k < 3; k++) s[k] += hess_plane[k][yk * MAX_WIDTH + xk];
        end
      end
    end
    res.xx = scale_by_radius(s[0], r);
    res.yy = scale_by_radius(s[1], r);
    res.xy = scale_by_radius(s[2], r);
    return res;
  endfunction

  function automatic hreq_t mk_req(op_t op, int col, int row, int pix, int sel, int tap,
                                   int coef, int rad);
    hreq_t q;
    q.op = op;
    q.col = col[7:0];
    q.row = row[7:0];
    q.pix = pix[15:0];
    q.sel = sel[1:0];
    q.tap = tap[5:0];
    q.coef = coef[23:0];
    q.rad = rad[7:0];
    return q;
  endfunction

  function automatic int draw_gap();
    if (calm || ($urandom_range(0, 3) == 0)) return 0;
    return $urandom_range(0, 18);
  endfunction

  // drive one request, wait for it to be taken, then update the predictor
  task automatic send_req(hreq_t q, bit typed, hres_t typed_res);
    int gap;
    int w, h;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= q.op;
    in_col <= q.col;
    in_row <= q.row;
    in_pixel_value <= q.pix;
    in_kernel_select <= q.sel;
    in_kernel_tap <= q.tap;
    in_coefficient <= q.coef;
    in_radius <= q.rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_req++;
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    case (q.op)
      OP_WRITE_PIXEL: begin
        frame_px[clamp_to(q.row, h - 1) * MAX_WIDTH + clamp_to(q.col, w - 1)] = q.pix;
        frame_ok[clamp_to(q.row, h - 1) * MAX_WIDTH + clamp_to(q.col, w - 1)] = 1;
      end
      OP_WRITE_KERNEL: begin
        if (q.sel <= KSEL_XY && q.tap < KTAPS) kern_tab[q.sel][q.tap] = longint'($signed(q.coef));
      end
      OP_COMPUTE: begin
        plane_build();
        n_compute++;
      end
      default: begin
        n_query++;
        pending_res.push_back(typed ? typed_res : disk_average(q.col, q.row, q.rad));
      end
    endcase
  endtask

  task automatic plain_req(hreq_t q);
    hres_t none;
    none = '{0, 0, 0};
    send_req(q, 0, none);
  endtask

  // all 147 taps; mode 0 random, 1 all at the top, 2 all at the bottom
  task automatic load_kernels(int mode);
    int c;
    for (int k = KSEL_XX; k <= KSEL_XY; k++) begin
      for (int t = 0; t < KTAPS; t++) begin
        c = (mode == 1) ? 8388607 : (mode == 2) ? -8388608 : int'($urandom);
        plain_req(mk_req(OP_WRITE_KERNEL, $urandom, $urandom, $urandom, k, t, c, $urandom));
      end
    end
  endtask

  // write every pixel of the frame that holds no value yet
  task automatic fill_frame();
    int v;
    for (int y = 0; y < eff_dim(reg_h); y++) begin
      for (int x = 0; x < eff_dim(reg_w); x++) begin
        if (!frame_ok[y * MAX_WIDTH + x]) begin
          v = ($urandom_range(0, 7) == 0) ? 65535 : int'($urandom_range(0, 65535));
          plain_req(mk_req(OP_WRITE_PIXEL, x, y, v, $urandom, $urandom, $urandom, $urandom));
        end
      end
    end
  endtask

  // sender stops, all results drain, then a compute still running is let finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (eff_dim(reg_w) * eff_dim(reg_h) * 49 + 1400) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, int v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= APB_AW'(int'(idx) * 4);
    pwdata <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) reg_w = v[8:0];
    else reg_h = v[8:0];
  endtask

  task automatic reg_check(reg_idx_t idx, int want);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= APB_AW'(int'(idx) * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[8:0] != want[8:0]) begin
      $display("%0t register %0d read: expected %0d actual %0d", $time, idx, want, prdata);
      n_fail++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random traffic on one frame size: mostly queries on fresh planes, some rewrites,
  // recomputes and ignored kernel writes as noise
  task automatic run_phase(int wv, int hv, int n_items, int kmode, bit calm_start, bit squeeze);
    int pick, w, h;
    settle();
    reg_write(REG_WIDTH, wv);
    reg_write(REG_HEIGHT, hv);
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    if (kmode >= 0) load_kernels(kmode);
    fill_frame();
    plain_req(mk_req(OP_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom));
    if (squeeze) hold_req = 1;
    for (int i = 0; i < n_items; i++) begin
      calm = calm_start && (i < 20);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        plain_req(mk_req(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                               : $urandom_range(0, 255)));
      end else if (pick < 77) begin
        plain_req(mk_req(OP_WRITE_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom));
      end else if (pick < 85) begin
        plain_req(mk_req(OP_WRITE_KERNEL, $urandom, $urandom, $urandom, $urandom_range(0, 2),
                         $urandom_range(0, KTAPS - 1), $urandom, $urandom));
      end else if (pick < 90) begin
        // ignored: table three or a tap past the end
        if ($urandom_range(0, 1) == 1)
          plain_req(mk_req(OP_WRITE_KERNEL, $urandom, $urandom, $urandom, 3, $urandom,
                           $urandom, $urandom));
        else
          plain_req(mk_req(OP_WRITE_KERNEL, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(KTAPS, 63), $urandom, $urandom));
        i--;
      end else if (w * h <= 64 || pick < 91) begin
        plain_req(mk_req(OP_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom));
      end else begin
        i--;
      end
    end
    calm = 0;
  endtask

  // result side: random hold-off per result, one long hold-off on request
  initial begin : result_sink
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = calm ? 0 : draw_gap();
      if (hold_req) begin
        hold_req = 0;
        n = 3000;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    hres_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result: actual %0d %0d %0d", $time, out_hxx, out_hyy,
                 out_hxy);
        n_fail++;
      end else begin
        want = pending_res.pop_front();
        n_checked++;
        if (out_hxx !== want.xx) begin
          $display("%0t hxx: expected %0d actual %0d", $time, want.xx, out_hxx);
          n_fail++;
        end
        if (out_hyy !== want.yy) begin
          $display("%0t hyy: expected %0d actual %0d", $time, want.yy, out_hyy);
          n_fail++;
        end
        if (out_hxy !== want.xy) begin
          $display("%0t hxy: expected %0d actual %0d", $time, want.xy, out_hxy);
          n_fail++;
        end
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("hessian_gaussian_disk_average_core_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_tab [$];
    hres_t zero;
    zero = '{0, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_check(REG_WIDTH, 256);
    reg_check(REG_HEIGHT, 256);

    // directed part on a one-pixel frame, so every tap lands on the same sample
    reg_write(REG_WIDTH, 1);
    reg_write(REG_HEIGHT, 1);
    load_kernels(0);
    dir_tab.push_back('{mk_req(OP_WRITE_PIXEL, 255, 255, 0, 0, 0, 0, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 0, zero});
    // zero sample gives zero planes, whatever the kernels and radius
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 255, 255, 0, 0, 0, 0, 255), 1, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 16), 1, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_PIXEL, 0, 0, 65535, 0, 0, 0, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_KERNEL, 0, 0, 0, KSEL_XX, 0, -8388608, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_KERNEL, 0, 0, 0, KSEL_YY, 48, 8388607, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_KERNEL, 0, 0, 0, KSEL_XY, 24, 0, 0), 0, zero});
    // ignored kernel writes
    dir_tab.push_back('{mk_req(OP_WRITE_KERNEL, 0, 0, 0, 3, 5, 123, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_KERNEL, 0, 0, 0, KSEL_XX, 49, 77, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_KERNEL, 0, 0, 0, KSEL_XY, 63, -1, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 0, zero});
    // radius zero taken as one sixteenth, then walk bound edges
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 1), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 15), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 16), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 240), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 255), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 255, 255, 0, 3, 63, -1, 100), 0, zero});
    dir_tab.push_back('{mk_req(OP_WRITE_PIXEL, 128, 7, 23130, 0, 0, 0, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 0, zero});
    dir_tab.push_back('{mk_req(OP_QUERY, 9, 200, 0, 0, 0, 0, 33), 0, zero});
    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

    // random phases over frame sizes and the register extremes
    run_phase(4, 4, 40, -1, 1, 0);
    run_phase(0, 0, 20, -1, 0, 1);
    run_phase(511, 1, 20, -1, 1, 0);
    run_phase(3, 2, 20, -1, 0, 1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("covered %0d requests: %0d queries checked of %0d, %0d computes,", n_req,
             n_checked, n_query, n_compute);
    $display("frame sizes from one pixel to a full row, register values zero and past the top");
    if (n_fail == 0 && pending_res.size() == 0) begin
      $display("hessian_gaussian_disk_average_core_tb: PASS");
    end else begin
      $display("hessian_gaussian_disk_average_core_tb: FAIL");
    end
    $finish;
  end

endmodule
